// ----- src/rlbe_pkg.sv -----
// ---------------------------------------------------------------------------
// rlbe_pkg - shared types and constants for the byte run-length encoder
// Token limits, literal store geometry and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package rlbe_pkg;

   localparam int unsigned MAX_RUN     = 128;
   localparam int unsigned STORE_DEPTH = 128;
   localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
   localparam int unsigned LANES       = 8;

   // one token to be emitted: a count byte, then either a value or the store
   typedef struct packed {
      logic       valid;
      logic       is_run;
      logic [7:0] head;
      logic [7:0] value;
      logic [7:0] last_idx;
   } seg_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic use_seg2;
      logic final_seg;
   } ctrl_cmd_type;

   typedef struct packed {
      logic plan_seg1;
      logic plan_seg2;
      logic seg2_held;
      logic seg_end;
      logic byte_ok;
   } ctrl_sts_type;

endpackage

// ----- src/run_length_byte_encoder_unit.sv -----
// An item that emits nothing causes no output; otherwise its bytes leave the emitter
// one a cycle while the result side does not stall, with a gap after each full word,
// and the next item is taken once its final byte has left (up to 131 bytes in up to
// 17 words per item).
// Throughput is set by the byte-serial emitter and its single literal store read port.
// Reset clears token state and output register; the literal store needs no clearing.
// ---------------------------------------------------------------------------
// run_length_byte_encoder_unit - byte run-length encoder, top level
// Sequencer, token datapath and word packer.
// ---------------------------------------------------------------------------
module run_length_byte_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_data,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_plane_end
);

   rlbe_pkg::ctrl_cmd_type cmd;
   rlbe_pkg::ctrl_sts_type sts;
   logic       byte_ok;
   logic       push;
   logic [7:0] push_byte;
   logic       push_final;
   logic       push_plane;

   rlbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rlbe_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .cmd             (cmd),
      .sts             (sts),
      .byte_ok         (byte_ok),
      .push            (push),
      .push_byte       (push_byte),
      .push_final      (push_final),
      .push_plane      (push_plane)
   );

   rlbe_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_byte      (push_byte),
      .push_final     (push_final),
      .push_plane     (push_plane),
      .byte_ok        (byte_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last_word  (rsp_last_word),
      .rsp_plane_end  (rsp_plane_end)
   );

endmodule

// ----- src/rlbe_ctrl.sv -----
// ---------------------------------------------------------------------------
// rlbe_ctrl - sequencer for the byte run-length encoder
// Takes an item, then walks the datapath through up to two tokens.
// ---------------------------------------------------------------------------
module rlbe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rlbe_pkg::ctrl_sts_type sts,
   output rlbe_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT1,
      ST_EMIT2
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      seg_done;

   assign seg_done  = sts.byte_ok & sts.seg_end;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               if (sts.plan_seg1) begin
                  state_in = ST_EMIT1;
               end else if (sts.plan_seg2) begin
                  state_in = ST_EMIT2;
               end
            end
         end
         ST_EMIT1: begin
            cmd.emit      = 1'b1;
            cmd.final_seg = ~sts.seg2_held;
            if (seg_done) begin
               state_in = sts.seg2_held ? ST_EMIT2 : ST_IDLE;
            end
         end
         ST_EMIT2: begin
            cmd.emit      = 1'b1;
            cmd.use_seg2  = 1'b1;
            cmd.final_seg = 1'b1;
            if (seg_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/rlbe_dpath.sv -----
// ---------------------------------------------------------------------------
// rlbe_dpath - token state, literal store and byte emitter
// Plans the tokens an item causes, then streams their bytes one a cycle while the packer accepts them.
// ---------------------------------------------------------------------------
module rlbe_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_sample,
   input  logic                   req_last_sample,
   input  rlbe_pkg::ctrl_cmd_type cmd,
   output rlbe_pkg::ctrl_sts_type sts,
   input  logic                   byte_ok,
   output logic                   push,
   output logic [7:0]             push_byte,
   output logic                   push_final,
   output logic                   push_plane
);

   typedef enum logic [1:0] {
      MODE_EMPTY,
      MODE_LIT,
      MODE_RUN
   } mode_type;

   localparam logic [7:0] LEN_MAX = 8'(rlbe_pkg::MAX_RUN);

   function automatic rlbe_pkg::seg_type lit_seg(input logic [7:0] n);
      rlbe_pkg::seg_type s;
      logic [7:0]        m;
      m          = n - 8'd1;
      s.valid    = (n != 8'd0);
      s.is_run   = 1'b0;
      s.head     = {1'b0, m[6:0]};
      s.value    = 8'd0;
      s.last_idx = n;
      return s;
   endfunction

   function automatic rlbe_pkg::seg_type run_seg(input logic [7:0] n, input logic [7:0] v);
      rlbe_pkg::seg_type s;
      logic [7:0]        m;
      m          = n - 8'd1;
      s.valid    = 1'b1;
      s.is_run   = 1'b1;
      s.head     = {1'b1, m[6:0]};
      s.value    = v;
      s.last_idx = 8'd1;
      return s;
   endfunction

   // token state
   mode_type   mode_ff, mode_in;
   logic [7:0] lit_len_ff, lit_len_in;
   logic [7:0] run_val_ff, run_val_in;
   logic [7:0] run_len_ff, run_len_in;
   logic [7:0] prev_ff, prev_in;

   // plan for the item being taken
   rlbe_pkg::seg_type plan1, plan2;
   logic                          plan_wr;
   logic [rlbe_pkg::STORE_AW-1:0] plan_addr;
   logic                          open_lit;

   // held plan while emitting
   rlbe_pkg::seg_type seg1_ff, seg2_ff, cur;
   logic       wr_pend_ff;
   logic [7:0] wr_val_ff;
   logic       plane_ff;
   logic [7:0] idx_ff;
   logic [7:0] idx_dec;

   logic [7:0] store_mem [rlbe_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;
   logic                          wr_en;
   logic [rlbe_pkg::STORE_AW-1:0] wr_addr;
   logic [7:0]                    wr_data;
   logic [rlbe_pkg::STORE_AW-1:0] rd_addr;

   logic advance;
   logic seg_end;

   always_comb begin
      plan1      = '0;
      plan2      = '0;
      plan_wr    = 1'b0;
      plan_addr  = '0;
      open_lit   = 1'b0;
      mode_in    = mode_ff;
      lit_len_in = lit_len_ff;
      run_val_in = run_val_ff;
      run_len_in = run_len_ff;
      prev_in    = prev_ff;
      if (mode_ff == MODE_LIT && lit_len_ff != 8'd0) begin
         if (lit_len_ff >= LEN_MAX) begin
            plan1    = lit_seg(lit_len_ff);
            open_lit = 1'b1;
         end else if (req_sample == prev_ff) begin
            // predecessor leaves the literal and the pair opens a run
            plan1      = lit_seg(lit_len_ff - 8'd1);
            lit_len_in = 8'd0;
            run_val_in = req_sample;
            run_len_in = 8'd2;
            mode_in    = MODE_RUN;
         end else begin
            plan_wr    = 1'b1;
            plan_addr  = lit_len_ff[rlbe_pkg::STORE_AW-1:0];
            lit_len_in = lit_len_ff + 8'd1;
            prev_in    = req_sample;
         end
      end else if (mode_ff == MODE_RUN && run_len_ff != 8'd0) begin
         if (req_sample == run_val_ff && run_len_ff < LEN_MAX) begin
            run_len_in = run_len_ff + 8'd1;
            prev_in    = req_sample;
         end else begin
            plan1    = run_seg(run_len_ff, run_val_ff);
            open_lit = 1'b1;
         end
      end else begin
         open_lit = 1'b1;
      end

      if (open_lit) begin
         plan_wr    = 1'b1;
         plan_addr  = '0;
         lit_len_in = 8'd1;
         prev_in    = req_sample;
         run_len_in = 8'd0;
         mode_in    = MODE_LIT;
      end

      if (req_last_sample) begin
         if (mode_in == MODE_LIT) begin
            plan2 = lit_seg(lit_len_in);
         end else if (mode_in == MODE_RUN) begin
            plan2 = run_seg(run_len_in, run_val_in);
         end
         mode_in    = MODE_EMPTY;
         lit_len_in = 8'd0;
         run_len_in = 8'd0;
      end
   end

   assign cur     = cmd.use_seg2 ? seg2_ff : seg1_ff;
   assign advance = cmd.emit & byte_ok;
   assign seg_end = (idx_ff == cur.last_idx);
   assign idx_dec = idx_ff - 8'd1;

   // store write: straight away when nothing is read first, otherwise once
   // the first token has read the old contents
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = wr_val_ff;
      if (cmd.load) begin
         wr_en   = plan_wr & ~plan1.valid;
         wr_addr = plan_addr;
         wr_data = req_sample;
      end else if (advance && seg_end && !cmd.use_seg2) begin
         wr_en = wr_pend_ff;
      end
   end

   // read one byte ahead; on a stall re-read the byte on show
   assign rd_addr = advance ? idx_ff[rlbe_pkg::STORE_AW-1:0]
                            : idx_dec[rlbe_pkg::STORE_AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_EMPTY;
         lit_len_ff <= 8'd0;
         run_val_ff <= 8'd0;
         run_len_ff <= 8'd0;
         prev_ff    <= 8'd0;
         idx_ff     <= 8'd0;
         wr_pend_ff <= 1'b0;
         seg1_ff    <= '0;
         seg2_ff    <= '0;
         plane_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff    <= mode_in;
            lit_len_ff <= lit_len_in;
            run_val_ff <= run_val_in;
            run_len_ff <= run_len_in;
            prev_ff    <= prev_in;
            seg1_ff    <= plan1;
            seg2_ff    <= plan2;
            wr_pend_ff <= plan_wr & plan1.valid;
            plane_ff   <= req_last_sample;
            idx_ff     <= 8'd0;
         end else if (advance) begin
            idx_ff <= seg_end ? 8'd0 : idx_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wr_val_ff <= req_sample;
      end
   end

   assign push       = advance;
   assign push_final = cmd.final_seg & seg_end;
   assign push_plane = plane_ff;

   always_comb begin
      if (idx_ff == 8'd0) begin
         push_byte = cur.head;
      end else if (cur.is_run) begin
         push_byte = cur.value;
      end else begin
         push_byte = rd_data_ff;
      end
   end

   assign sts.plan_seg1 = plan1.valid;
   assign sts.plan_seg2 = plan2.valid;
   assign sts.seg2_held = seg2_ff.valid;
   assign sts.seg_end   = seg_end;
   assign sts.byte_ok   = byte_ok;

endmodule

// ----- src/rlbe_packer.sv -----
// ---------------------------------------------------------------------------
// rlbe_packer - byte to word packer and output register
// Gathers up to eight bytes, first in the low lane, and holds the word
// until it is taken.
// ---------------------------------------------------------------------------
module rlbe_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [7:0]  push_byte,
   input  logic        push_final,
   input  logic        push_plane,
   output logic        byte_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_data,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_plane_end
);

   logic        valid_ff;
   logic [63:0] data_ff, data_in;
   logic [3:0]  count_ff;
   logic        last_ff;
   logic        plane_ff;
   logic        full;

   assign byte_ok = ~valid_ff;
   assign full    = (count_ff == 4'(rlbe_pkg::LANES - 1));

   always_comb begin
      data_in = (count_ff == 4'd0) ? 64'd0 : data_ff;
      for (int l = 0; l < rlbe_pkg::LANES; l++) begin
         if (count_ff == 4'(l)) begin
            data_in[8*l +: 8] = push_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= 4'd0;
      end else if (valid_ff) begin
         if (rsp_ready) begin
            valid_ff <= 1'b0;
            count_ff <= 4'd0;
         end
      end else if (push) begin
         count_ff <= count_ff + 4'd1;
         valid_ff <= full | push_final;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !valid_ff) begin
         data_ff  <= data_in;
         last_ff  <= push_final;
         plane_ff <= push_final & push_plane;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data       = data_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_last_word  = last_ff;
   assign rsp_plane_end  = plane_ff;

endmodule

// ----- src/rlbe_checker.sv -----
// ---------------------------------------------------------------------------
// rlbe_checker - port checks for the byte run-length encoder
// Watches the result channel for malformed words.
// ---------------------------------------------------------------------------
module rlbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_data,
   input logic [3:0]  rsp_byte_count,
   input logic        rsp_last_word,
   input logic        rsp_plane_end
);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count >= 4'd1 && rsp_byte_count <= 4'd8))
      else $error("byte count out of range");

   a_inner_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> rsp_byte_count == 4'd8)
      else $error("word before the last one of an item is not full");

   a_plane_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plane_end |-> rsp_last_word)
      else $error("plane end on a word that is not the last of its item");

   a_lanes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count < 4'd8 |->
         (rsp_data >> {rsp_byte_count[2:0], 3'b000}) == 64'd0)
      else $error("unused byte lanes not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind run_length_byte_encoder_unit rlbe_checker u_rlbe_checker (.*);

// ----- verif/tb_run_length_byte_encoder_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_run_length_byte_encoder_unit - self-checking bench for the RLE encoder
// Drives plane bytes through the request channel, predicts the packed token
// words in a local encoder model and checks every result word in order.
// A short table of directed items is followed by random runs, literals and
// noise under three idling schemes.
// ---------------------------------------------------------------------------
module tb_run_length_byte_encoder_unit;

   typedef enum logic [1:0] {TOK_EMPTY, TOK_LITERAL, TOK_RUN} tok_mode_type;
   typedef enum int {SEG_RUN, SEG_LITERAL, SEG_NOISE, SEG_EXTREME} seg_kind_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last_word;
      logic        plane_end;
   } enc_word_type;

   // one item of stimulus; typed rows carry their single expected word
   typedef struct packed {
      logic [7:0]  sample;
      logic        is_last;
      logic        typed;
      logic [63:0] exp_data;
      logic [3:0]  exp_count;
   } stim_row_type;

   localparam int N_DIR = 21;
   localparam stim_row_type DIR_TABLE [N_DIR] = '{
      '{8'h00, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 4'd2},
      '{8'hFF, 1'b1, 1'b1, 64'h0000_0000_0000_FF00, 4'd2},
      '{8'hAA, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'hAA, 1'b1, 1'b1, 64'h0000_0000_0000_AA81, 4'd2},
      '{8'h12, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h34, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h34, 1'b1, 1'b1, 64'h0000_0000_3481_1200, 4'd4},
      '{8'h01, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h02, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h03, 1'b1, 1'b0, 64'd0, 4'd0},
      // repeat after a one-byte literal turns the pair into a run
      '{8'h7F, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h7F, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h80, 1'b1, 1'b0, 64'd0, 4'd0},
      // nine token bytes, so the flush spills into a second word
      '{8'h11, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h22, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h44, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h88, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'hF0, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h0F, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'h55, 1'b0, 1'b0, 64'd0, 4'd0},
      '{8'hC3, 1'b1, 1'b0, 64'd0, 4'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_sample = 8'd0;
   logic        req_last_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_data;
   logic [3:0]  rsp_byte_count;
   logic        rsp_last_word;
   logic        rsp_plane_end;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   int items_sent = 0;
   logic [7:0] last_sent = 8'd0;

   // encoder model state
   tok_mode_type tok_mode = TOK_EMPTY;
   logic [7:0]   lit_store [rlbe_pkg::STORE_DEPTH];
   logic [7:0]   lit_len = 8'd0;
   logic [7:0]   run_val = 8'd0;
   logic [7:0]   run_len = 8'd0;
   logic [7:0]   prev_byte = 8'd0;
   logic [7:0]   tok_bytes [$];
   enc_word_type step_words [$];
   enc_word_type exp_words [$];

   run_length_byte_encoder_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_word   (rsp_last_word),
      .rsp_plane_end   (rsp_plane_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function void emit_literal_bytes(input logic [7:0] n);
      if (n != 8'd0) begin
         tok_bytes.push_back((n - 8'd1) & 8'h7F);
         for (int i = 0; i < n; i++)
            tok_bytes.push_back(lit_store[i[6:0]]);
      end
   endfunction

   function void emit_run_bytes();
      tok_bytes.push_back(8'h80 | ((run_len - 8'd1) & 8'h7F));
      tok_bytes.push_back(run_val);
   endfunction

   function void open_literal(input logic [7:0] x);
      lit_store[0] = x;
      lit_len = 8'd1;
      prev_byte = x;
      run_len = 8'd0;
      tok_mode = TOK_LITERAL;
   endfunction

   // advance the model by one plane byte and pack its token bytes into words
   function void encode_sample(input logic [7:0] x, input logic is_last);
      enc_word_type w;
      int n, base, cnt;
      tok_bytes.delete();
      step_words.delete();
      if (tok_mode == TOK_LITERAL && lit_len != 8'd0) begin
         if (lit_len >= rlbe_pkg::MAX_RUN) begin
            // full literal: the new byte is not compared, it opens a token
            emit_literal_bytes(lit_len);
            open_literal(x);
         end else if (x == prev_byte) begin
            emit_literal_bytes(lit_len - 8'd1);
            lit_len = 8'd0;
            run_val = x;
            run_len = 8'd2;
            tok_mode = TOK_RUN;
         end else begin
            lit_store[lit_len[6:0]] = x;
            lit_len = lit_len + 8'd1;
            prev_byte = x;
         end
      end else if (tok_mode == TOK_RUN && run_len != 8'd0) begin
         if (x == run_val && run_len < rlbe_pkg::MAX_RUN) begin
            run_len = run_len + 8'd1;
            prev_byte = x;
         end else begin
            emit_run_bytes();
            open_literal(x);
         end
      end else begin
         open_literal(x);
      end
      if (is_last) begin
         if (tok_mode == TOK_LITERAL)
            emit_literal_bytes(lit_len);
         else if (tok_mode == TOK_RUN)
            emit_run_bytes();
         tok_mode = TOK_EMPTY;
         lit_len = 8'd0;
         run_len = 8'd0;
      end
      n = tok_bytes.size();
      base = 0;
      while (base < n) begin
         cnt = (n - base > rlbe_pkg::LANES) ? rlbe_pkg::LANES : n - base;
         w = '0;
         for (int i = 0; i < cnt; i++)
            w.data[8*i +: 8] = tok_bytes[base + i];
         w.count = cnt[3:0];
         w.last_word = (base + cnt == n);
         w.plane_end = is_last && (base + cnt == n);
         step_words.push_back(w);
         base += cnt;
      end
   endfunction

   function void flag_word(input string what, input enc_word_type want,
                           input enc_word_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected %h/%0d/%b/%b, got %h/%0d/%b/%b", $time, what,
                  want.data, want.count, want.last_word, want.plane_end,
                  got.data, got.count, got.last_word, got.plane_end);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input stim_row_type row);
      enc_word_type w;
      encode_sample(row.sample, row.is_last);
      if (row.typed) begin
         w.data = row.exp_data;
         w.count = row.exp_count;
         w.last_word = 1'b1;
         w.plane_end = row.is_last;
         exp_words.push_back(w);
      end else begin
         foreach (step_words[i])
            exp_words.push_back(step_words[i]);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= row.sample;
      req_last_sample <= row.is_last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      last_sent = row.sample;
      @(negedge clock);
   endtask

   task automatic send_segment(input seg_kind_type kind, input int len);
      logic [7:0] b;
      logic close_plane;
      stim_row_type row;
      close_plane = ($urandom_range(0, 3) == 0);
      b = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         case (kind)
            SEG_LITERAL: begin
               b = 8'($urandom);
               if (b == last_sent)
                  b = b ^ 8'h01;
            end
            SEG_NOISE: b = 8'($urandom_range(0, 3));
            SEG_EXTREME: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
         endcase
         row = '{b, close_plane && (i == len - 1), 1'b0, 64'd0, 4'd0};
         send_item(row);
      end
   endtask

   task automatic send_random_segment();
      int pick, len;
      pick = $urandom_range(0, 9);
      len = $urandom_range(1, 9);
      if (pick < 4)
         send_segment(SEG_RUN, (len < 2) ? 2 : len);
      else if (pick < 8)
         send_segment(SEG_LITERAL, len);
      else if (pick == 8)
         send_segment(SEG_NOISE, len);
      else
         send_segment(SEG_EXTREME, len);
   endtask

   task automatic run_phase(input int target, input int lead);
      int start;
      stim_row_type row;
      start = items_sent;
      if (lead == 0) begin
         // run past its cap
         send_segment(SEG_RUN, $urandom_range(129, 131));
      end else if (lead == 1) begin
         // full literal followed by a repeat of its final byte
         send_segment(SEG_LITERAL, rlbe_pkg::MAX_RUN);
         row = '{last_sent, 1'b0, 1'b0, 64'd0, 4'd0};
         send_item(row);
      end
      while (items_sent - start < target)
         send_random_segment();
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      enc_word_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.data = rsp_data;
         got.count = rsp_byte_count;
         got.last_word = rsp_last_word;
         got.plane_end = rsp_plane_end;
         if (exp_words.size() == 0) begin
            flag_word("unexpected word", '0, got);
         end else begin
            want = exp_words.pop_front();
            if (got.data !== want.data || got.count !== want.count ||
                got.last_word !== want.last_word || got.plane_end !== want.plane_end)
               flag_word("word mismatch", want, got);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 80;
      for (int i = 0; i < N_DIR; i++)
         send_item(DIR_TABLE[i]);
      run_phase(100, 0);

      send_idle_pct = 80;
      recv_idle_pct = 25;
      run_phase(100, 1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(10, 2);
      req_valid <= 1'b0;

      while (exp_words.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (exp_words.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- run_length_byte_encoder_unit.f -----
src/rlbe_pkg.sv
src/rlbe_ctrl.sv
src/rlbe_dpath.sv
src/rlbe_packer.sv
src/run_length_byte_encoder_unit.sv
src/rlbe_checker.sv
verif/tb_run_length_byte_encoder_unit.sv
